// ===== src/scd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_pkg
// Shared widths, constants and register indexes of the sensor change detector.
// ----------------------------------------------------------------------------
package scd_pkg;

  // field widths
  localparam int ADC_BITS      = 12;
  localparam int TIME_BITS     = 32;
  localparam int MOTION_BITS   = 16;
  localparam int CHAN_BITS     = 3;
  localparam int MAX_CHANNELS  = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // default number of luminance channels
  localparam int LUMIN_CHANNELS_DEF = 8;

  // time units
  localparam logic [6:0] MOTION_UNIT_MS = 7'd100;
  localparam logic [9:0] LUMIN_UNIT_MS  = 10'd1000;

  // reset values
  localparam logic [MOTION_BITS-1:0] MOTION_RESET_WORD = 16'h00fc;
  localparam logic [15:0] MOTION_MASK_RST     = 16'h00ff;
  localparam logic [7:0]  MOTION_INTERVAL_RST = 8'd20;
  localparam logic [7:0]  LUMIN_MASK_RST      = 8'hff;
  localparam logic [7:0]  LUMIN_INTERVAL_RST  = 8'd10;
  localparam logic [11:0] LUMIN_THRESHOLD_RST = 12'd0;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MOTION_MASK     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MOTION_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LUMIN_MASK      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LUMIN_INTERVAL  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LUMIN_THRESHOLD = 3'd4;

  // input modes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_SCAN   = 1'b1;

  // result word
  typedef struct packed {
    logic [MOTION_BITS-1:0]  motion_reported;
    logic                    motion_sampled;
    logic                    motion_changed;
    logic                    lumin_sampled;
    logic                    lumin_changed;
    logic [MAX_CHANNELS-1:0] lumin_change_bits;
    logic                    state_event;
  } scd_result_t;

endpackage
`default_nettype wire

// ===== src/scd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_in_if / scd_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface scd_in_if
  import scd_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [TIME_BITS-1:0]   now_ms;
  logic [MOTION_BITS-1:0] motion_raw;
  logic [CHAN_BITS-1:0]   channel;
  logic [ADC_BITS-1:0]    sample_first;
  logic [ADC_BITS-1:0]    sample_second;

  modport source (output valid, mode, now_ms, motion_raw, channel, sample_first,
                  sample_second, input ready);
  modport sink (input valid, mode, now_ms, motion_raw, channel, sample_first,
                sample_second, output ready);
endinterface

interface scd_out_if
  import scd_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [MOTION_BITS-1:0]  motion_reported;
  logic                    motion_sampled;
  logic                    motion_changed;
  logic                    lumin_sampled;
  logic                    lumin_changed;
  logic [MAX_CHANNELS-1:0] lumin_change_bits;
  logic                    state_event;

  modport source (output valid, motion_reported, motion_sampled, motion_changed,
                  lumin_sampled, lumin_changed, lumin_change_bits, state_event,
                  input ready);
  modport sink (input valid, motion_reported, motion_sampled, motion_changed,
                lumin_sampled, lumin_changed, lumin_change_bits, state_event,
                output ready);
endinterface
`default_nettype wire

// ===== src/scd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scd_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/sensor_change_detector.sv =====
// Sample word: taken and written to the current-value RAM; no result.
// Scan word: ST_TIME, then ST_WALK when luminance is due, then ST_DONE loads the result;
// the walk reads one channel per cycle from the two RAMs into one compare unit.
// Next word is taken the cycle after the result loads, not while a scan is in progress;
// a full result register holds the scan in its last step until the waiting word goes.
// Reset (synchronous, active high) restores registers, stamps, flags and RAM valid bits.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_change_detector
// Motion and luminance change detection with interval timing and RAM-held
// luminance history.
// ----------------------------------------------------------------------------
module sensor_change_detector
  import scd_pkg::*;
#(
  parameter int LUMIN_CHANNELS = LUMIN_CHANNELS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  scd_in_if.sink                        item_in,
  scd_out_if.source                     result_out
);

  localparam int CH_W  = (LUMIN_CHANNELS > 1) ? $clog2(LUMIN_CHANNELS) : 1;
  localparam int CNT_W = $clog2(LUMIN_CHANNELS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LUMIN_CHANNELS);
  localparam logic [CHAN_BITS:0] CHAN_LIMIT = LUMIN_CHANNELS[CHAN_BITS:0];

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TIME = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // configuration registers
  logic [15:0] motion_mask;
  logic [7:0]  motion_interval;
  logic [7:0]  lumin_mask;
  logic [7:0]  lumin_interval;
  logic [11:0] lumin_threshold;

  // control and scan state
  logic [1:0]             state;
  logic [TIME_BITS-1:0]   scan_now;
  logic [MOTION_BITS-1:0] scan_raw;
  logic [MOTION_BITS-1:0] motion_reported_reg;
  logic [MOTION_BITS-1:0] motion_previous;
  logic [TIME_BITS-1:0]   motion_stamp;
  logic [TIME_BITS-1:0]   lumin_stamp;
  logic [1:0]             flag_bits;
  logic [1:0]             flag_bits_previous;
  logic                   m_due;
  logic                   l_due;
  logic [MAX_CHANNELS-1:0] change_bits;
  logic [CNT_W-1:0]       rd_cnt;
  logic                   s1_valid;
  logic [CH_W-1:0]        s1_idx;
  logic [LUMIN_CHANNELS-1:0] cur_valid;
  logic [LUMIN_CHANNELS-1:0] prev_valid;

  // result register
  logic        out_valid;
  scd_result_t out_word;

  // ram ports
  logic                cur_we;
  logic [CH_W-1:0]     cur_waddr;
  logic [ADC_BITS-1:0] cur_wdata;
  logic [ADC_BITS-1:0] cur_rdata;
  logic [ADC_BITS-1:0] prev_rdata;
  logic [CH_W-1:0]     rd_addr;

  // compare path
  logic                 in_fire;
  logic                 sample_ok;
  logic [ADC_BITS:0]    sample_sum;
  logic [TIME_BITS-1:0] m_elapsed;
  logic [TIME_BITS-1:0] l_elapsed;
  logic [14:0]          m_limit;
  logic [17:0]          l_limit;
  logic                 m_due_now;
  logic                 l_due_now;
  logic [ADC_BITS-1:0]  cur_v;
  logic [ADC_BITS-1:0]  prev_v;
  logic [ADC_BITS-1:0]  diff;
  logic [MAX_CHANNELS-1:0] mask_sh;
  logic                 hit;
  logic [1:0]           flags_new;
  logic                 out_load;

  assign item_in.ready = (state == ST_IDLE);
  assign in_fire       = item_in.valid && (state == ST_IDLE);

  // sample word: truncated average into the current-value RAM
  assign sample_sum = {1'b0, item_in.sample_first} + {1'b0, item_in.sample_second};
  assign sample_ok  = ({1'b0, item_in.channel} < CHAN_LIMIT);
  assign cur_we     = in_fire && (item_in.mode == MODE_SAMPLE) && sample_ok;
  assign cur_waddr  = item_in.channel[CH_W-1:0];
  assign cur_wdata  = sample_sum[ADC_BITS:1];

  assign rd_addr = rd_cnt[CH_W-1:0];

  scd_ram #(
    .WIDTH (ADC_BITS),
    .DEPTH (LUMIN_CHANNELS)
  ) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .raddr (rd_addr),
    .rdata (cur_rdata)
  );

  scd_ram #(
    .WIDTH (ADC_BITS),
    .DEPTH (LUMIN_CHANNELS)
  ) u_prev_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_idx),
    .wdata (cur_v),
    .raddr (rd_addr),
    .rdata (prev_rdata)
  );

  // interval checks
  assign m_elapsed = scan_now - motion_stamp;
  assign l_elapsed = scan_now - lumin_stamp;
  assign m_limit   = 15'(motion_interval) * 15'(MOTION_UNIT_MS);
  assign l_limit   = 18'(lumin_interval) * 18'(LUMIN_UNIT_MS);
  assign m_due_now = (motion_interval != 8'd0) && (m_elapsed > TIME_BITS'(m_limit));
  assign l_due_now = (lumin_interval != 8'd0) && (l_elapsed > TIME_BITS'(l_limit));

  // channel compare unit, unwritten entries read as zero
  assign cur_v   = cur_valid[s1_idx]  ? cur_rdata  : '0;
  assign prev_v  = prev_valid[s1_idx] ? prev_rdata : '0;
  assign diff    = (cur_v >= prev_v) ? (cur_v - prev_v) : (prev_v - cur_v);
  assign mask_sh = lumin_mask >> s1_idx;
  assign hit     = (lumin_threshold != 12'd0) && mask_sh[0] && (diff >= lumin_threshold);

  // flags after this scan
  assign flags_new = {(l_due ? (change_bits != '0) : flag_bits[1]), flag_bits[0]};
  assign out_load  = (state == ST_DONE) && (!out_valid || result_out.ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_mask     <= MOTION_MASK_RST;
      motion_interval <= MOTION_INTERVAL_RST;
      lumin_mask      <= LUMIN_MASK_RST;
      lumin_interval  <= LUMIN_INTERVAL_RST;
      lumin_threshold <= LUMIN_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOTION_MASK:     motion_mask     <= cfg_data;
        REG_MOTION_INTERVAL: motion_interval <= cfg_data[7:0];
        REG_LUMIN_MASK:      lumin_mask      <= cfg_data[7:0];
        REG_LUMIN_INTERVAL:  lumin_interval  <= cfg_data[7:0];
        REG_LUMIN_THRESHOLD: lumin_threshold <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      motion_reported_reg <= MOTION_RESET_WORD;
      motion_previous     <= '0;
      motion_stamp        <= '0;
      lumin_stamp         <= '0;
      flag_bits           <= '0;
      flag_bits_previous  <= '0;
      m_due               <= 1'b0;
      l_due               <= 1'b0;
      change_bits         <= '0;
      rd_cnt              <= '0;
      s1_valid            <= 1'b0;
      cur_valid           <= '0;
      prev_valid          <= '0;
    end else begin
      if (cur_we) begin
        cur_valid[cur_waddr] <= 1'b1;
      end
      s1_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_fire && (item_in.mode == MODE_SCAN)) begin
            state <= ST_TIME;
          end
        end
        ST_TIME: begin
          m_due       <= m_due_now;
          l_due       <= l_due_now;
          change_bits <= '0;
          rd_cnt      <= '0;
          if (m_due_now) begin
            motion_stamp        <= scan_now;
            motion_reported_reg <= scan_raw;
            motion_previous     <= scan_raw;
            flag_bits[0]        <= ((motion_mask & scan_raw) != (motion_mask & motion_previous));
          end
          if (l_due_now) begin
            lumin_stamp <= scan_now;
            state       <= ST_WALK;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_WALK: begin
          // issue one read per cycle, compare it in the cycle after
          if (rd_cnt != CNT_LAST) begin
            rd_cnt   <= rd_cnt + 1'b1;
            s1_valid <= 1'b1;
            s1_idx   <= rd_addr;
          end else if (!s1_valid) begin
            state <= ST_DONE;
          end
          if (s1_valid) begin
            prev_valid[s1_idx] <= 1'b1;
            if (hit) begin
              change_bits <= change_bits | (MAX_CHANNELS'(1) << s1_idx);
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            flag_bits          <= flags_new;
            flag_bits_previous <= flags_new;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // scan word capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      scan_now <= item_in.now_ms;
      scan_raw <= item_in.motion_raw;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word.motion_reported   <= motion_reported_reg;
      out_word.motion_sampled    <= m_due;
      out_word.motion_changed    <= flags_new[0];
      out_word.lumin_sampled     <= l_due;
      out_word.lumin_changed     <= flags_new[1];
      out_word.lumin_change_bits <= l_due ? change_bits : '0;
      out_word.state_event       <= (flags_new != flag_bits_previous);
    end
  end

  assign result_out.valid             = out_valid;
  assign result_out.motion_reported   = out_word.motion_reported;
  assign result_out.motion_sampled    = out_word.motion_sampled;
  assign result_out.motion_changed    = out_word.motion_changed;
  assign result_out.lumin_sampled     = out_word.lumin_sampled;
  assign result_out.lumin_changed     = out_word.lumin_changed;
  assign result_out.lumin_change_bits = out_word.lumin_change_bits;
  assign result_out.state_event       = out_word.state_event;

endmodule
`default_nettype wire
